>>> rtl/fqs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fqs_pkg
// Shared types and constants for the fifo queue with search.
// ---------------------------------------------------------------------------
package fqs_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int DIST_W = 4;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_SEARCH = 2'd3
  } req_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SRCH = 2'b10
  } state_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic                     found;
    logic [DIST_W-1:0]        distance;
    logic                     is_empty;
    logic [1:0]               status;
  } out_beat_t;

  typedef struct packed {
    logic                     shift;
    logic                     search;
    logic signed [DATA_W-1:0] key;
  } cell_ctl_t;

endpackage

>>> rtl/fqs_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fqs_cell
// One queue slot: loads a pushed value, takes its neighbor's value on a pop,
// and registers a compare against the search key.
// ---------------------------------------------------------------------------
module fqs_cell
  import fqs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cell_ctl_t                ctl,
  input  logic                     load,
  input  logic                     live,
  input  logic signed [DATA_W-1:0] nbr_value,
  output logic signed [DATA_W-1:0] value,
  output logic                     hit
);

  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic                     hit_r, hit_nxt;

  always_comb begin
    value_nxt = value_r;
    if (load) begin
      value_nxt = ctl.key;
    end else if (ctl.shift) begin
      value_nxt = nbr_value;
    end
  end

  always_comb begin
    hit_nxt = hit_r;
    if (ctl.search) begin
      hit_nxt = live && (value_r == ctl.key);
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  assign value = value_r;
  assign hit   = hit_r;

endmodule

>>> rtl/fqs_prienc.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fqs_prienc
// Priority encoder over the cell hit flags: lowest hit is nearest the head.
// ---------------------------------------------------------------------------
module fqs_prienc
  import fqs_pkg::*;
(
  input  logic [DEPTH-1:0] hits,
  output logic             found,
  output logic [IDX_W-1:0] idx
);

  always_comb begin
    idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hits[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

  assign found = |hits;

endmodule

>>> rtl/fifo_queue_with_search_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fifo_queue_with_search_core
// Bounded fifo of signed 32-bit values with push, pop, peek and search.
// ---------------------------------------------------------------------------
// The queue is a row of DEPTH cells with the head always in cell 0: push
// writes the cell at the fill count, pop shifts every cell one place toward
// the head. Push, pop and peek beats can be taken every cycle while the
// output register is free. A search has all cells compare against the key,
// then the priority encoder picks the hit nearest the head; the next beat
// is taken once the search result is registered. One result beat is
// produced per request, held in an output register.
module fifo_queue_with_search_core
  import fqs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_beat_t                out_data_r, out_data_nxt;
  logic                     out_free;
  logic                     accept;
  logic                     is_push, is_pop, is_peek, is_search;
  logic                     full, empty;
  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]         hits;
  logic                     enc_found;
  logic [IDX_W-1:0]         enc_idx;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign is_push   = in_data.req_type == REQ_PUSH;
  assign is_pop    = in_data.req_type == REQ_POP;
  assign is_peek   = in_data.req_type == REQ_PEEK;
  assign is_search = in_data.req_type == REQ_SEARCH;
  assign full      = fill_r == CNT_W'(DEPTH);
  assign empty     = fill_r == '0;

  assign ctl.shift  = accept && is_pop && !empty;
  assign ctl.search = accept && is_search;
  assign ctl.key    = in_data.value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] nbr;
    if (i == DEPTH - 1) begin : g_last
      assign nbr = cell_val[i];
    end else begin : g_mid
      assign nbr = cell_val[i+1];
    end
    fqs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .load      (accept && is_push && (fill_r == CNT_W'(i))),
      .live      (CNT_W'(i) < fill_r),
      .nbr_value (nbr),
      .value     (cell_val[i]),
      .hit       (hits[i])
    );
  end

  fqs_prienc u_prienc (
    .hits  (hits),
    .found (enc_found),
    .idx   (enc_idx)
  );

  always_comb begin
    fill_nxt      = fill_r;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (is_search) begin
            state_nxt = S_SRCH;
          end else begin
            out_data_nxt = '0;
            if (is_push) begin
              if (full) begin
                out_data_nxt.status = ST_FULL;
              end else begin
                fill_nxt = fill_r + 1'b1;
              end
            end else if (is_pop || is_peek) begin
              if (empty) begin
                out_data_nxt.status = ST_EMPTY;
              end else begin
                out_data_nxt.data = cell_val[0];
                if (is_pop) begin
                  fill_nxt = fill_r - 1'b1;
                end
              end
            end
            out_data_nxt.is_empty = fill_nxt == '0;
            out_valid_nxt         = 1'b1;
          end
        end
      end
      S_SRCH: begin
        if (out_free) begin
          out_data_nxt          = '0;
          out_data_nxt.found    = enc_found;
          out_data_nxt.distance = enc_found ? DIST_W'(enc_idx) : '0;
          out_data_nxt.is_empty = empty;
          out_data_nxt.status   = ST_OK;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/fqs_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fqs_checker
// Port-level checks on the request and result beats of the fifo queue with
// search.
// ---------------------------------------------------------------------------
module fqs_checker
  import fqs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_EMPTY) |-> out_data.is_empty && (out_data.data == '0))
    else $error("empty error beat carries data or non-empty flag");

  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.req_type == REQ_SEARCH) |=> in_stall)
    else $error("request beat taken while a search is in progress");

  a_search_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> !out_data.is_empty && (out_data.status == ST_OK))
    else $error("search hit on empty queue or with error status");

  a_no_hit_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.distance == '0)
    else $error("distance set without a search hit");

endmodule

bind fifo_queue_with_search_core fqs_checker u_fqs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> test/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking testbench for fifo_queue_with_search_core.
// ---------------------------------------------------------------------------
// A shadow queue predicts the response to every accepted request beat. The
// expected responses are compared field by field against the output beats.
// Directed tasks cover requests on an empty queue, the value extremes and a
// full queue. A long output hold-off backs the block up into its input.
// A random phase then fills and drains the queue many times, with duplicate
// values and search keys taken from the queue contents, under random gaps
// on both sides.
// ---------------------------------------------------------------------------
module tb;
  import fqs_pkg::*;

  localparam int LIMIT = 200000;
  localparam int HOLD  = 80;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  logic signed [DATA_W-1:0] shadow_fifo[$];
  out_beat_t                pending_resp[$];
  logic signed [DATA_W-1:0] dup_pool[4];

  int errors = 0;
  int cycles = 0;
  int hold_left = 0;
  int stall_run = 0;
  int free_run = 0;
  bit stall_en = 1'b0;
  bit gaps_on = 1'b0;
  int n_push = 0, n_pop = 0, n_peek = 0, n_search = 0;
  int n_hit = 0, n_full = 0, n_empty = 0, max_fill = 0, n_resp = 0;

  fifo_queue_with_search_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // response of the queue to one request, updates the shadow queue
  function automatic out_beat_t next_response(in_beat_t b);
    out_beat_t r;
    r = '0;
    r.status = ST_OK;
    case (req_t'(b.req_type))
      REQ_PUSH: begin
        n_push++;
        if (shadow_fifo.size() >= DEPTH) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          shadow_fifo.push_back(b.value);
        end
      end
      REQ_POP, REQ_PEEK: begin
        if (req_t'(b.req_type) == REQ_POP) n_pop++;
        else n_peek++;
        if (shadow_fifo.size() == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          r.data = shadow_fifo[0];
          if (req_t'(b.req_type) == REQ_POP) void'(shadow_fifo.pop_front());
        end
      end
      default: begin
        n_search++;
        for (int i = 0; i < shadow_fifo.size(); i++) begin
          if (shadow_fifo[i] == b.value) begin
            r.found = 1'b1;
            r.distance = i[DIST_W-1:0];
            n_hit++;
            break;
          end
        end
      end
    endcase
    r.is_empty = (shadow_fifo.size() == 0);
    if (shadow_fifo.size() > max_fill) max_fill = shadow_fifo.size();
    return r;
  endfunction

  task automatic report_error(input string msg);
    errors++;
    if (errors <= 20) $display("tb: ERROR at cycle %0d: %s", cycles, msg);
  endtask

  task automatic cmp_field(input string name, input logic [DATA_W-1:0] got,
                           input logic [DATA_W-1:0] want);
    if (got !== want) report_error($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // output beat checker
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_resp++;
      if (pending_resp.size() == 0) begin
        report_error("response beat with none expected");
      end else begin
        want = pending_resp.pop_front();
        cmp_field("data", out_data.data, want.data);
        cmp_field("found", DATA_W'(out_data.found), DATA_W'(want.found));
        cmp_field("distance", DATA_W'(out_data.distance), DATA_W'(want.distance));
        cmp_field("is_empty", DATA_W'(out_data.is_empty), DATA_W'(want.is_empty));
        cmp_field("status", DATA_W'(out_data.status), DATA_W'(want.status));
      end
    end
  end

  // receiver stall generator
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!stall_en) begin
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else begin
      out_stall <= 1'b0;
      if (free_run > 0) begin
        free_run--;
      end else begin
        stall_run = pick_gap();
        free_run = $urandom_range(0, 5);
      end
    end
  end

  task automatic send_beat(input req_t kind, input logic signed [DATA_W-1:0] val);
    in_beat_t b;
    int g;
    b.req_type = kind;
    b.value = val;
    in_data <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_resp.push_back(next_response(b));
    g = gaps_on ? pick_gap() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic test_empty_queue();
    send_beat(REQ_POP, VAL_MAX);
    send_beat(REQ_PEEK, VAL_MIN);
    send_beat(REQ_SEARCH, 32'sd0);
  endtask

  task automatic test_fill_and_extremes();
    logic signed [DATA_W-1:0] tail_val;
    tail_val = $urandom;
    send_beat(REQ_PUSH, VAL_MIN);
    send_beat(REQ_PUSH, VAL_MAX);
    send_beat(REQ_PUSH, 32'sd0);
    send_beat(REQ_PUSH, -32'sd1);
    for (int i = 4; i < DEPTH - 1; i++) send_beat(REQ_PUSH, (i == 7) ? VAL_MAX : $urandom);
    send_beat(REQ_PUSH, tail_val);
    // full queue, push is dropped
    send_beat(REQ_PUSH, $urandom);
    send_beat(REQ_SEARCH, VAL_MIN);
    send_beat(REQ_SEARCH, VAL_MAX);
    send_beat(REQ_SEARCH, tail_val);
    send_beat(REQ_SEARCH, 32'sd1);
    send_beat(REQ_PEEK, 32'sd0);
    send_beat(REQ_POP, -32'sd1);
  endtask

  task automatic test_backpressure();
    int r;
    gaps_on = 1'b0;
    stall_en = 1'b0;
    hold_left = HOLD;
    for (int i = 0; i < 30; i++) begin
      r = $urandom_range(0, 3);
      send_beat(req_t'(r), $urandom);
    end
  endtask

  task automatic test_random(input int n_items);
    bit fill_up;
    int r;
    req_t kind;
    logic signed [DATA_W-1:0] val;
    fill_up = 1'b0;
    foreach (dup_pool[i]) dup_pool[i] = $urandom;
    for (int k = 0; k < n_items; k++) begin
      if (k % 50 == 0) begin
        gaps_on = ($urandom_range(0, 2) != 0);
        stall_en = ($urandom_range(0, 2) != 0);
      end
      if (fill_up && shadow_fifo.size() == DEPTH && $urandom_range(0, 3) == 0) fill_up = 1'b0;
      if (!fill_up && shadow_fifo.size() == 0 && $urandom_range(0, 3) == 0) fill_up = 1'b1;
      r = $urandom_range(0, 99);
      if (fill_up) kind = (r < 60) ? REQ_PUSH : (r < 75) ? REQ_POP : (r < 85) ? REQ_PEEK : REQ_SEARCH;
      else kind = (r < 15) ? REQ_PUSH : (r < 65) ? REQ_POP : (r < 75) ? REQ_PEEK : REQ_SEARCH;
      r = $urandom_range(0, 99);
      val = $urandom;
      if (kind == REQ_PUSH && r < 25) begin
        val = dup_pool[$urandom_range(0, 3)];
      end else if (kind == REQ_SEARCH) begin
        if (r < 60 && shadow_fifo.size() > 0)
          val = shadow_fifo[$urandom_range(0, shadow_fifo.size() - 1)];
        else if (r < 80)
          val = dup_pool[$urandom_range(0, 3)];
      end
      send_beat(kind, val);
    end
    gaps_on = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queue();
    test_fill_and_extremes();
    test_backpressure();
    test_random(400);
    in_valid <= 1'b0;
    stall_en = 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("tb: %0d responses checked: %0d push, %0d pop, %0d peek, %0d search",
             n_resp, n_push, n_pop, n_peek, n_search);
    $display("tb: %0d search hits, %0d dropped pushes, %0d empty accesses, max fill %0d",
             n_hit, n_full, n_empty, max_fill);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
